/* hw/rtl/mdep_pkg.sv */
// ----------------------------------------------------------------------------
// mdep_pkg
// Types and constants shared by the note-length expression parser.
// ----------------------------------------------------------------------------
package mdep_pkg;

    localparam int CHAR_W    = 8;
    localparam int STEP_W    = 10;  // whole/quarter note step registers
    localparam int ACC_W     = 16;  // parsed number
    localparam int CNT_W     = 4;
    localparam int DIV_STEPS = 10;  // one quotient bit per cycle
    localparam int HEX_DIGITS = 2;
    localparam int BIN_DIGITS = 8;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_CARET   = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_TILDE   = 8'h7E;

    localparam logic REG_WHOLE   = 1'b0;
    localparam logic REG_QUARTER = 1'b1;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_EOL   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_BEGIN,
        KIND_CHAR,
        KIND_EOL
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] data;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_head_t;

    typedef enum logic [1:0] {
        CTX_LEAD_PCT,
        CTX_LEAD_DIV,
        CTX_TIE_PCT,
        CTX_TIE_DIV
    } ctx_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DFLT,
        PH_LEAD,
        PH_INT_START,
        PH_INT_SIGNED,
        PH_HEX,
        PH_BIN_PEEK,
        PH_BIN,
        PH_DEC,
        PH_DOT,
        PH_TDOT,
        PH_TIE,
        PH_TIE_OP,
        PH_NDONE,
        PH_NDIV,
        PH_FIN
    } phase_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] dividend;
        logic [ACC_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [STEP_W-1:0] quot;
    } div_rsp_t;

endpackage

/* hw/rtl/mdep_in_if.sv */
// ----------------------------------------------------------------------------
// mdep_in_if
// Input channel: command, character and default length.
// ----------------------------------------------------------------------------
interface mdep_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_code;
    logic [7:0] default_length;

    modport source (output valid, command, char_code, default_length, input ready);
    modport sink   (input valid, command, char_code, default_length, output ready);
endinterface

/* hw/rtl/mdep_out_if.sv */
// ----------------------------------------------------------------------------
// mdep_out_if
// Result channel: duration, leftover character count and clip flag.
// ----------------------------------------------------------------------------
interface mdep_out_if #(
    parameter int DURATION_WIDTH = 16
);
    logic                             valid;
    logic                             ready;
    logic signed [DURATION_WIDTH-1:0] duration;
    logic [1:0]                       leftover_chars;
    logic                             clipped;

    modport source (output valid, duration, leftover_chars, clipped, input ready);
    modport sink   (input valid, duration, leftover_chars, clipped, output ready);
endinterface

/* hw/rtl/mdep_front.sv */
// ----------------------------------------------------------------------------
// mdep_front
// Accepts input items, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
module mdep_front (
    input  logic             clk,
    input  logic             rst_n,
    mdep_in_if.sink          in_ch,
    input  logic             pop,
    output mdep_pkg::q_head_t head
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    mdep_pkg::q_item_t      fifo_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;
    mdep_pkg::q_item_t      new_item;
    logic                   keep;
    logic                   push;

    always_comb
    begin
        new_item.kind = mdep_pkg::KIND_CHAR;
        new_item.data = in_ch.char_code;
        keep          = 1'b1;
        unique case (mdep_pkg::cmd_t'(in_ch.command))
            mdep_pkg::CMD_BEGIN:
            begin
                new_item.kind = mdep_pkg::KIND_BEGIN;
                new_item.data = in_ch.default_length;
            end
            mdep_pkg::CMD_CHAR:
            begin
                if (in_ch.char_code == mdep_pkg::CH_NUL)
                    new_item.kind = mdep_pkg::KIND_EOL;
            end
            mdep_pkg::CMD_EOL:
            begin
                new_item.kind = mdep_pkg::KIND_EOL;
            end
            default:
            begin
                keep = 1'b0;   // unused command code is dropped
            end
        endcase
    end

    assign in_ch.ready = (count_reg != (PTR_W+1)'(DEPTH));
    assign push        = in_ch.valid && in_ch.ready && keep;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= new_item;
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = fifo_reg[rd_ptr_reg];

endmodule

/* hw/rtl/mdep_div.sv */
// ----------------------------------------------------------------------------
// mdep_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mdep_div (
    input  logic               clk,
    input  logic               rst_n,
    input  mdep_pkg::div_req_t req,
    output mdep_pkg::div_rsp_t rsp
);

    localparam int QW = mdep_pkg::STEP_W;
    localparam int RW = mdep_pkg::ACC_W;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [mdep_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [QW-1:0]               quot_reg, quot_next;
    logic [RW-1:0]               rem_reg, rem_next;
    logic [RW-1:0]               dvs_reg, dvs_next;
    logic [RW:0]                 rem_sh;
    logic                        ge;

    assign rem_sh = {rem_reg, quot_reg[QW-1]};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[QW-2:0], ge};
            rem_next  = ge ? RW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[RW-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == mdep_pkg::CNT_W'(mdep_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

/* hw/rtl/mdep_back.sv */
// ----------------------------------------------------------------------------
// mdep_back
// Parser sequencer: walks the queued items through the length grammar,
// drives the shared divider and holds the result register.
// ----------------------------------------------------------------------------
module mdep_back #(
    parameter int DURATION_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mdep_pkg::STEP_W-1:0]    whole_steps,
    input  logic [mdep_pkg::STEP_W-1:0]    quarter_steps,
    input  mdep_pkg::q_head_t              head,
    output logic                           pop,
    output mdep_pkg::div_req_t             div_req,
    input  mdep_pkg::div_rsp_t             div_rsp,
    mdep_out_if.source                     out_ch
);

    localparam int W  = DURATION_WIDTH;
    localparam int TW = (W > 11) ? W : 11;          // also holds unclamped 1023
    localparam int DW = TW - 1;                     // dot increment, never negative
    localparam int SW = ((TW > 17) ? TW : 17) + 1;  // adder width
    localparam int AW = mdep_pkg::ACC_W;
    localparam int CW = mdep_pkg::CNT_W;
    localparam logic signed [SW-1:0] DUR_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] DUR_LO = -DUR_HI - SW'(1);

    mdep_pkg::phase_t        phase_reg, phase_next;
    mdep_pkg::ctx_t          ctx_reg, ctx_next;
    logic [AW-1:0]           acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic signed [TW-1:0]    total_reg, total_next;
    logic [DW-1:0]           dot_reg, dot_next;
    logic                    sub_reg, sub_next;
    logic                    sat_reg, sat_next;
    logic                    pct_reg, pct_next;
    logic                    finp_reg, finp_next;
    logic                    fin_eol_reg, fin_eol_next;
    logic [mdep_pkg::STEP_W-1:0] dflt_reg, dflt_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [W-1:0]     out_dur_reg, out_dur_next;
    logic [1:0]              out_left_reg, out_left_next;
    logic                    out_clip_reg, out_clip_next;

    logic [7:0]              ch;
    logic                    is_char, is_eol, is_begin;
    logic                    ws, dig, bitc;
    logic [4:0]              hexv;
    logic [3:0]              dval;
    logic [AW+3:0]           dec_full;
    logic signed [16:0]      val;
    logic signed [SW-1:0]    add_a, add_b, sum, sum_sat;
    logic                    add_sub, ovf;
    logic [DW-1:0]           dot_half;

    assign ch       = head.item.data;
    assign is_begin = head.valid && (head.item.kind == mdep_pkg::KIND_BEGIN);
    assign is_eol   = (head.item.kind == mdep_pkg::KIND_EOL);
    assign is_char  = (head.item.kind == mdep_pkg::KIND_CHAR);
    assign ws       = is_char && (ch == mdep_pkg::CH_SPACE || ch == mdep_pkg::CH_TAB);
    assign dig      = is_char && ch >= mdep_pkg::CH_ZERO && ch <= mdep_pkg::CH_NINE;
    assign bitc     = is_char && (ch == mdep_pkg::CH_ZERO || ch == mdep_pkg::CH_ONE);
    assign dval     = ch[3:0];
    assign dot_half = dot_reg >> 1;
    assign val      = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign dec_full = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + (AW+4)'(dval);

    always_comb
    begin
        hexv = 5'd16;
        if (is_char)
        begin
            if (ch >= mdep_pkg::CH_ZERO && ch <= mdep_pkg::CH_NINE)
                hexv = {1'b0, ch[3:0]};
            else if ((ch >= mdep_pkg::CH_LO_A && ch <= mdep_pkg::CH_LO_F) ||
                     (ch >= mdep_pkg::CH_UP_A && ch <= mdep_pkg::CH_UP_F))
                hexv = 5'(ch[3:0]) + 5'd9;
        end
    end

    // adder operand select
    always_comb
    begin
        add_a   = SW'(total_reg);
        add_b   = '0;
        add_sub = sub_reg;
        unique case (phase_reg)
            mdep_pkg::PH_DOT:
            begin
                add_b   = SW'(dot_half);
                add_sub = 1'b0;
            end
            mdep_pkg::PH_TDOT:   add_b = SW'(dot_half);
            mdep_pkg::PH_TIE_OP: add_b = SW'(dflt_reg);
            mdep_pkg::PH_NDIV:   add_b = SW'(div_rsp.quot);
            mdep_pkg::PH_NDONE:
            begin
                add_b = SW'(val);
                if (ctx_reg == mdep_pkg::CTX_LEAD_PCT)
                begin
                    add_a   = '0;
                    add_sub = 1'b0;
                end
            end
            default: add_b = '0;
        endcase
    end

    always_comb
    begin
        sum = add_sub ? add_a - add_b : add_a + add_b;
        ovf = 1'b1;
        if (sum > DUR_HI)
            sum_sat = DUR_HI;
        else if (sum < DUR_LO)
            sum_sat = DUR_LO;
        else
        begin
            sum_sat = sum;
            ovf     = 1'b0;
        end
    end

    // next state and datapath
    always_comb
    begin
        phase_next     = phase_reg;
        ctx_next       = ctx_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        dot_next       = dot_reg;
        sub_next       = sub_reg;
        sat_next       = sat_reg;
        pct_next       = pct_reg;
        finp_next      = finp_reg;
        fin_eol_next   = fin_eol_reg;
        dflt_next      = dflt_reg;
        pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = whole_steps;
        div_req.divisor  = acc_reg;

        unique case (phase_reg)
            mdep_pkg::PH_DFLT:
            begin
                if (div_rsp.done)
                begin
                    dflt_next  = div_rsp.quot;
                    phase_next = mdep_pkg::PH_LEAD;
                end
            end
            mdep_pkg::PH_NDONE:
            begin
                unique case (ctx_reg)
                    mdep_pkg::CTX_LEAD_PCT:
                    begin
                        if (neg_reg && acc_reg != '0)
                        begin
                            total_next = TW'(dflt_reg);
                            dot_next   = DW'(dflt_reg);
                        end
                        else
                        begin
                            total_next = sum_sat[TW-1:0];
                            dot_next   = sum_sat[DW-1:0];
                            sat_next   = sat_reg | ovf;
                        end
                        phase_next = mdep_pkg::PH_DOT;
                    end
                    mdep_pkg::CTX_LEAD_DIV:
                    begin
                        if (acc_reg != '0)
                        begin
                            div_req.start = 1'b1;
                            phase_next    = mdep_pkg::PH_NDIV;
                        end
                        else
                        begin
                            total_next = TW'(dflt_reg);
                            dot_next   = DW'(dflt_reg);
                            phase_next = mdep_pkg::PH_DOT;
                        end
                    end
                    mdep_pkg::CTX_TIE_PCT:
                    begin
                        total_next = sum_sat[TW-1:0];
                        sat_next   = sat_reg | ovf;
                        phase_next = mdep_pkg::PH_TIE;
                    end
                    default:
                    begin
                        if (acc_reg != '0)
                        begin
                            div_req.start = 1'b1;
                            phase_next    = mdep_pkg::PH_NDIV;
                        end
                        else
                        begin
                            dot_next   = '0;
                            phase_next = mdep_pkg::PH_TDOT;
                        end
                    end
                endcase
                // percent held back: the expression ends right here
                if (finp_reg)
                begin
                    finp_next  = 1'b0;
                    phase_next = mdep_pkg::PH_FIN;
                end
            end
            mdep_pkg::PH_NDIV:
            begin
                if (div_rsp.done)
                begin
                    dot_next = DW'(div_rsp.quot);
                    if (ctx_reg == mdep_pkg::CTX_LEAD_DIV)
                    begin
                        total_next = TW'(div_rsp.quot);
                        phase_next = mdep_pkg::PH_DOT;
                    end
                    else
                    begin
                        total_next = sum_sat[TW-1:0];
                        sat_next   = sat_reg | ovf;
                        phase_next = mdep_pkg::PH_TDOT;
                    end
                end
            end
            mdep_pkg::PH_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                    phase_next = mdep_pkg::PH_IDLE;
            end
            default:
            begin
                if (is_begin)
                begin
                    pop          = 1'b1;
                    acc_next     = '0;
                    neg_next     = 1'b0;
                    cnt_next     = '0;
                    total_next   = '0;
                    dot_next     = '0;
                    sub_next     = 1'b0;
                    sat_next     = 1'b0;
                    ctx_next     = mdep_pkg::CTX_LEAD_PCT;
                    pct_next     = 1'b0;
                    finp_next    = 1'b0;
                    if (ch != '0)
                    begin
                        div_req.start   = 1'b1;
                        div_req.divisor = AW'(ch);
                        phase_next      = mdep_pkg::PH_DFLT;
                    end
                    else
                    begin
                        dflt_next  = quarter_steps;
                        phase_next = mdep_pkg::PH_LEAD;
                    end
                end
                else if (head.valid)
                begin
                    unique case (phase_reg)
                        mdep_pkg::PH_LEAD:
                        begin
                            if (ws)
                                pop = 1'b1;
                            else if (is_char && ch == mdep_pkg::CH_PERCENT)
                            begin
                                pop        = 1'b1;
                                acc_next   = '0;
                                neg_next   = 1'b0;
                                cnt_next   = '0;
                                ctx_next   = mdep_pkg::CTX_LEAD_PCT;
                                phase_next = mdep_pkg::PH_INT_START;
                            end
                            else if (dig)
                            begin
                                pop        = 1'b1;
                                acc_next   = AW'(dval);
                                neg_next   = 1'b0;
                                cnt_next   = '0;
                                ctx_next   = mdep_pkg::CTX_LEAD_DIV;
                                phase_next = mdep_pkg::PH_DEC;
                            end
                            else
                            begin
                                total_next = TW'(dflt_reg);
                                dot_next   = DW'(dflt_reg);
                                phase_next = mdep_pkg::PH_DOT;
                            end
                        end
                        mdep_pkg::PH_INT_START:
                        begin
                            if (ws)
                                pop = 1'b1;
                            else
                            begin
                                phase_next = mdep_pkg::PH_INT_SIGNED;
                                if (is_char && ch == mdep_pkg::CH_MINUS)
                                begin
                                    pop      = 1'b1;
                                    neg_next = 1'b1;
                                end
                                else if (is_char && ch == mdep_pkg::CH_PLUS)
                                    pop = 1'b1;
                            end
                        end
                        mdep_pkg::PH_INT_SIGNED:
                        begin
                            if (is_char && ch == mdep_pkg::CH_DOLLAR)
                            begin
                                pop        = 1'b1;
                                phase_next = mdep_pkg::PH_HEX;
                            end
                            else if (is_char && ch == mdep_pkg::CH_PERCENT)
                            begin
                                pop        = 1'b1;
                                pct_next   = 1'b1;
                                phase_next = mdep_pkg::PH_BIN_PEEK;
                            end
                            else if (dig)
                            begin
                                pop        = 1'b1;
                                acc_next   = AW'(dval);
                                phase_next = mdep_pkg::PH_DEC;
                            end
                            else
                                phase_next = mdep_pkg::PH_NDONE;
                        end
                        mdep_pkg::PH_HEX:
                        begin
                            if (hexv != 5'd16)
                            begin
                                pop      = 1'b1;
                                acc_next = {acc_reg[AW-5:0], hexv[3:0]};
                                cnt_next = cnt_reg + 1'b1;
                                if (cnt_reg + 1'b1 >= CW'(mdep_pkg::HEX_DIGITS))
                                    phase_next = mdep_pkg::PH_NDONE;
                            end
                            else
                                phase_next = mdep_pkg::PH_NDONE;
                        end
                        mdep_pkg::PH_BIN_PEEK:
                        begin
                            pop = 1'b1;
                            if (bitc)
                            begin
                                pct_next   = 1'b0;
                                acc_next   = AW'(ch[0]);
                                cnt_next   = CW'(1);
                                phase_next = mdep_pkg::PH_BIN;
                            end
                            else
                            begin
                                finp_next    = 1'b1;
                                fin_eol_next = is_eol;
                                phase_next   = mdep_pkg::PH_NDONE;
                            end
                        end
                        mdep_pkg::PH_BIN:
                        begin
                            if (bitc)
                            begin
                                pop      = 1'b1;
                                acc_next = {acc_reg[AW-2:0], ch[0]};
                                cnt_next = cnt_reg + 1'b1;
                                if (cnt_reg + 1'b1 >= CW'(mdep_pkg::BIN_DIGITS))
                                    phase_next = mdep_pkg::PH_NDONE;
                            end
                            else if (is_char && ch == mdep_pkg::CH_UNDER)
                                pop = 1'b1;
                            else
                                phase_next = mdep_pkg::PH_NDONE;
                        end
                        mdep_pkg::PH_DEC:
                        begin
                            if (dig)
                            begin
                                pop = 1'b1;
                                if (dec_full[AW+3:AW] != '0)
                                begin
                                    acc_next = '1;
                                    sat_next = 1'b1;
                                end
                                else
                                    acc_next = dec_full[AW-1:0];
                            end
                            else
                                phase_next = mdep_pkg::PH_NDONE;
                        end
                        mdep_pkg::PH_DOT, mdep_pkg::PH_TDOT:
                        begin
                            if (is_char && ch == mdep_pkg::CH_DOT)
                            begin
                                pop        = 1'b1;
                                dot_next   = dot_half;
                                total_next = sum_sat[TW-1:0];
                                sat_next   = sat_reg | ovf;
                            end
                            else
                                phase_next = mdep_pkg::PH_TIE;
                        end
                        mdep_pkg::PH_TIE:
                        begin
                            pop = 1'b1;
                            if (is_char && (ch == mdep_pkg::CH_CARET ||
                                            ch == mdep_pkg::CH_TILDE))
                            begin
                                sub_next   = (ch == mdep_pkg::CH_TILDE);
                                phase_next = mdep_pkg::PH_TIE_OP;
                            end
                            else
                            begin
                                fin_eol_next = is_eol;
                                phase_next   = mdep_pkg::PH_FIN;
                            end
                        end
                        mdep_pkg::PH_TIE_OP:
                        begin
                            if (is_char && ch == mdep_pkg::CH_PERCENT)
                            begin
                                pop        = 1'b1;
                                acc_next   = '0;
                                neg_next   = 1'b0;
                                cnt_next   = '0;
                                ctx_next   = mdep_pkg::CTX_TIE_PCT;
                                phase_next = mdep_pkg::PH_INT_START;
                            end
                            else if (dig)
                            begin
                                pop        = 1'b1;
                                acc_next   = AW'(dval);
                                neg_next   = 1'b0;
                                cnt_next   = '0;
                                ctx_next   = mdep_pkg::CTX_TIE_DIV;
                                phase_next = mdep_pkg::PH_DEC;
                            end
                            else
                            begin
                                total_next = sum_sat[TW-1:0];
                                sat_next   = sat_reg | ovf;
                                phase_next = mdep_pkg::PH_TIE;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;   // idle: characters and line ends dropped
                        end
                    endcase
                end
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_dur_next   = out_dur_reg;
        out_left_next  = out_left_reg;
        out_clip_next  = out_clip_reg;
        if (phase_reg == mdep_pkg::PH_FIN && (!out_valid_reg || out_ch.ready))
        begin
            out_valid_next = 1'b1;
            out_dur_next   = total_reg[W-1:0];
            out_left_next  = {1'b0, pct_reg} + {1'b0, !fin_eol_reg};
            out_clip_next  = sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mdep_pkg::PH_IDLE;
            ctx_reg       <= mdep_pkg::CTX_LEAD_PCT;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            dot_reg       <= '0;
            sub_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            pct_reg       <= 1'b0;
            finp_reg      <= 1'b0;
            fin_eol_reg   <= 1'b0;
            dflt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            ctx_reg       <= ctx_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            dot_reg       <= dot_next;
            sub_reg       <= sub_next;
            sat_reg       <= sat_next;
            pct_reg       <= pct_next;
            finp_reg      <= finp_next;
            fin_eol_reg   <= fin_eol_next;
            dflt_reg      <= dflt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dur_reg  <= out_dur_next;
        out_left_reg <= out_left_next;
        out_clip_reg <= out_clip_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.duration       = out_dur_reg;
    assign out_ch.leftover_chars = out_left_reg;
    assign out_ch.clipped        = out_clip_reg;

endmodule

/* hw/rtl/mml_duration_expression_parser.sv */
// ----------------------------------------------------------------------------
// mml_duration_expression_parser
// Note-length expression parser: front queue, parser sequencer, divider.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    command, char_code, default_length
//   out_ch    out  valid/ready    duration, leftover_chars, clipped
//   cfg       in   cfg_write      cfg_index, cfg_data
//
// In the sequencer a character that closes a number walks several phases
// before it is consumed, and the one that ends the expression also passes
// through the phase that loads the result register.
// Closing a nonzero length divisor, or a begin with a nonzero default,
// runs the shared bit-serial divider (10 quotient bits).
// A 4-entry queue lets input items arrive while the sequencer divides or
// the result register waits to be taken. Reset empties the queue and
// sets the registers to 192 and 48 steps.
// ----------------------------------------------------------------------------
module mml_duration_expression_parser #(
    parameter int DURATION_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    mdep_in_if.sink     in_ch,
    mdep_out_if.source  out_ch,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data
);

    logic [mdep_pkg::STEP_W-1:0] whole_reg, quarter_reg;
    mdep_pkg::q_head_t           head;
    logic                        pop;
    mdep_pkg::div_req_t          div_req;
    mdep_pkg::div_rsp_t          div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg   <= mdep_pkg::STEP_W'(192);
            quarter_reg <= mdep_pkg::STEP_W'(48);
        end
        else if (cfg_write)
        begin
            if (cfg_index == mdep_pkg::REG_WHOLE)
                whole_reg <= cfg_data;
            else
                quarter_reg <= cfg_data;
        end
    end

    mdep_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .pop   (pop),
        .head  (head)
    );

    mdep_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mdep_back #(
        .DURATION_WIDTH (DURATION_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .whole_steps   (whole_reg),
        .quarter_steps (quarter_reg),
        .head          (head),
        .pop           (pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .out_ch        (out_ch)
    );

`ifndef SYNTH
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_leftover_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.leftover_chars != 2'd3))
        else $error("leftover count out of range");
`endif

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the note-length expression parser. Items are driven through the
// input channel with random gaps and the results are compared against a
// cycle-free model of the parser kept in this module. A short table of
// directed items is run first, then random expressions under several
// register settings.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DUR_W    = 16;
    localparam longint DUR_MAX  = 32767;
    localparam longint DUR_MIN  = -32768;
    localparam int     STALL_LIMIT = 4000;
    localparam int     SETTLE   = 60;
    localparam int     ITEM_GOAL = 800;

    typedef enum {
        S_IDLE, S_LEAD, S_ISTART, S_ISIGN, S_HEX, S_BPEEK, S_BIN, S_DEC,
        S_DOT, S_TDOT, S_TIE, S_TIEOP
    } stage_t;

    typedef enum { N_LPCT, N_LDIV, N_TPCT, N_TDIV } num_ctx_t;

    typedef struct {
        logic signed [DUR_W-1:0] dur;
        logic [1:0]              left;
        logic                    clip;
    } length_t;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [7:0] dl;
        bit         typed;
        int         dur;
        int         left;
        bit         clip;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_index = mdep_pkg::REG_WHOLE;
    logic [9:0] cfg_data = '0;

    mdep_in_if               in_ch ();
    mdep_out_if #(.DURATION_WIDTH(DUR_W)) out_ch ();

    mml_duration_expression_parser #(.DURATION_WIDTH(DUR_W)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // parser model state
    int unsigned whole_steps = 192;
    int unsigned quarter_steps = 48;
    stage_t      stage = S_IDLE;
    num_ctx_t    nctx = N_LPCT;
    int unsigned acc = 0;
    bit          neg = 0;
    int          digits = 0;
    longint      total = 0;
    longint      incr = 0;
    bit          tie_sub = 0;
    int unsigned held_dl = 0;
    bit          sat = 0;
    bit          pct_held = 0;

    length_t pending_lengths[$];
    int      errors = 0;
    int      items_sent = 0;
    int      stall_cycles = 0;
    bit      calm = 0;

    row_t dir_rows[] = '{
        '{mdep_pkg::CMD_BEGIN, 8'h00, 8'd0,   1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_EOL,   8'h41, 8'd0,   1'b1, 48, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  8'h61, 8'd9,   1'b0, 0, 0, 1'b0},   // idle, ignored
        '{mdep_pkg::CMD_NONE,  8'hFF, 8'hFF,  1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_BEGIN, 8'h00, 8'd4,   1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_DOT, 8'd0,  1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_NUL, 8'd0,  1'b1, 72, 0, 1'b0},  // NUL as EOL
        '{mdep_pkg::CMD_BEGIN, 8'h00, 8'd255, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_PERCENT, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_MINUS, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_NINE, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  8'h78, 8'd0,   1'b1, 0, 1, 1'b0},   // negative -> default
        '{mdep_pkg::CMD_BEGIN, 8'h00, 8'd7,   1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_ONE, 8'd0,  1'b0, 0, 0, 1'b0},   // expression abandoned by the next begin
        '{mdep_pkg::CMD_BEGIN, 8'h00, 8'd1,   1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_PERCENT, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_DOLLAR, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_UP_F, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_LO_F, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_TILDE, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_PERCENT, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_PERCENT, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_EOL,   8'h00, 8'd0,   1'b1, 255, 1, 1'b0},  // held percent
        '{mdep_pkg::CMD_BEGIN, 8'h00, 8'd2,   1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_NINE, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_NINE, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_NINE, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_NINE, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_NINE, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_CHAR,  mdep_pkg::CH_CARET, 8'd0, 1'b0, 0, 0, 1'b0},
        '{mdep_pkg::CMD_EOL,   8'h00, 8'd0,   1'b1, 96, 0, 1'b1}   // divisor saturates
    };

    function automatic longint clamp_len(longint v);
        if (v > DUR_MAX) begin sat = 1; return DUR_MAX; end
        if (v < DUR_MIN) begin sat = 1; return DUR_MIN; end
        return v;
    endfunction

    function automatic longint default_len();
        if (held_dl > 0)
            return longint'(whole_steps / held_dl);
        return longint'(quarter_steps);
    endfunction

    function automatic void add_tie(longint v);
        total = clamp_len(tie_sub ? total - v : total + v);
    endfunction

    function automatic void open_number(num_ctx_t c, stage_t s);
        acc = 0;
        neg = 0;
        digits = 0;
        nctx = c;
        stage = s;
    endfunction

    function automatic void close_number();
        longint v;
        longint a;
        v = neg ? -longint'(acc) : longint'(acc);
        case (nctx)
            N_LPCT: begin
                total = (v < 0) ? default_len() : clamp_len(v);
                incr = total;
                stage = S_DOT;
            end
            N_LDIV: begin
                total = (acc > 0) ? longint'(whole_steps / acc) : default_len();
                incr = total;
                stage = S_DOT;
            end
            N_TPCT: begin
                add_tie(v);
                stage = S_TIE;
            end
            default: begin
                a = (acc > 0) ? longint'(whole_steps / acc) : 0;
                add_tie(a);
                incr = a;
                stage = S_TDOT;
            end
        endcase
    endfunction

    // Runs one character through the parse; returns 1 when a length comes out.
    function automatic bit parse_char(logic [7:0] c, bit eol);
        bit ws, dig, bt, again;
        int hv;
        again = 1;
        while (again) begin
            again = 0;
            ws  = !eol && (c == mdep_pkg::CH_SPACE || c == mdep_pkg::CH_TAB);
            dig = !eol && c >= mdep_pkg::CH_ZERO && c <= mdep_pkg::CH_NINE;
            bt  = !eol && (c == mdep_pkg::CH_ZERO || c == mdep_pkg::CH_ONE);
            if (dig)
                hv = c - mdep_pkg::CH_ZERO;
            else if (!eol && c >= mdep_pkg::CH_LO_A && c <= mdep_pkg::CH_LO_F)
                hv = c - mdep_pkg::CH_LO_A + 10;
            else if (!eol && c >= mdep_pkg::CH_UP_A && c <= mdep_pkg::CH_UP_F)
                hv = c - mdep_pkg::CH_UP_A + 10;
            else
                hv = 16;
            case (stage)
                S_LEAD: begin
                    if (ws) ;
                    else if (!eol && c == mdep_pkg::CH_PERCENT)
                        open_number(N_LPCT, S_ISTART);
                    else if (dig) begin
                        open_number(N_LDIV, S_DEC);
                        acc = c - mdep_pkg::CH_ZERO;
                    end else begin
                        total = default_len();
                        incr = total;
                        stage = S_DOT;
                        again = 1;
                    end
                end
                S_ISTART: begin
                    if (!ws) begin
                        stage = S_ISIGN;
                        if (!eol && c == mdep_pkg::CH_MINUS) neg = 1;
                        else if (!(!eol && c == mdep_pkg::CH_PLUS)) again = 1;
                    end
                end
                S_ISIGN: begin
                    if (!eol && c == mdep_pkg::CH_DOLLAR) stage = S_HEX;
                    else if (!eol && c == mdep_pkg::CH_PERCENT) begin
                        pct_held = 1;
                        stage = S_BPEEK;
                    end else if (dig) begin
                        acc = c - mdep_pkg::CH_ZERO;
                        stage = S_DEC;
                    end else begin
                        close_number();
                        again = 1;
                    end
                end
                S_HEX: begin
                    if (hv < 16) begin
                        acc = acc * 16 + hv;
                        digits++;
                        if (digits >= mdep_pkg::HEX_DIGITS) close_number();
                    end else begin
                        close_number();
                        again = 1;
                    end
                end
                S_BPEEK: begin
                    if (bt) begin
                        pct_held = 0;
                        acc = c - mdep_pkg::CH_ZERO;
                        digits = 1;
                        stage = S_BIN;
                    end else begin
                        close_number();
                        stage = S_IDLE;
                        return 1;
                    end
                end
                S_BIN: begin
                    if (bt) begin
                        acc = acc * 2 + (c - mdep_pkg::CH_ZERO);
                        digits++;
                        if (digits >= mdep_pkg::BIN_DIGITS) close_number();
                    end else if (!(!eol && c == mdep_pkg::CH_UNDER)) begin
                        close_number();
                        again = 1;
                    end
                end
                S_DEC: begin
                    if (dig) begin
                        acc = acc * 10 + (c - mdep_pkg::CH_ZERO);
                        if (acc > 65535) begin
                            acc = 65535;
                            sat = 1;
                        end
                    end else begin
                        close_number();
                        again = 1;
                    end
                end
                S_DOT, S_TDOT: begin
                    if (!eol && c == mdep_pkg::CH_DOT) begin
                        incr = incr / 2;
                        if (stage == S_DOT) total = clamp_len(total + incr);
                        else                add_tie(incr);
                    end else begin
                        stage = S_TIE;
                        again = 1;
                    end
                end
                S_TIE: begin
                    if (!eol && (c == mdep_pkg::CH_CARET || c == mdep_pkg::CH_TILDE)) begin
                        tie_sub = (c == mdep_pkg::CH_TILDE);
                        stage = S_TIEOP;
                    end else begin
                        stage = S_IDLE;
                        return 1;
                    end
                end
                S_TIEOP: begin
                    if (!eol && c == mdep_pkg::CH_PERCENT) open_number(N_TPCT, S_ISTART);
                    else if (dig) begin
                        open_number(N_TDIV, S_DEC);
                        acc = c - mdep_pkg::CH_ZERO;
                    end else begin
                        add_tie(default_len());
                        stage = S_TIE;
                        again = 1;
                    end
                end
                default: ;
            endcase
        end
        return 0;
    endfunction

    // Applies one accepted input item; returns 1 with the length when one is due.
    function automatic bit parser_step(logic [1:0] cmd, logic [7:0] c, logic [7:0] dl,
                                       output length_t r);
        bit eol;
        r = '{dur: '0, left: '0, clip: 1'b0};
        if (cmd == mdep_pkg::CMD_BEGIN) begin
            stage = S_LEAD;
            acc = 0; neg = 0; digits = 0; total = 0; incr = 0;
            tie_sub = 0; sat = 0; nctx = N_LPCT; pct_held = 0;
            held_dl = dl;
            return 0;
        end
        if (cmd == mdep_pkg::CMD_NONE || stage == S_IDLE)
            return 0;
        eol = (cmd == mdep_pkg::CMD_EOL) || (c == mdep_pkg::CH_NUL);
        if (!parse_char(c, eol))
            return 0;
        r.dur  = total[DUR_W-1:0];
        r.left = 2'(int'(pct_held) + (eol ? 0 : 1));
        r.clip = sat;
        return 1;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    task automatic send_item(logic [1:0] cmd, logic [7:0] c, logic [7:0] dl,
                             bit typed = 0, length_t want = '{0, 0, 0});
        length_t r;
        while (!calm && $urandom_range(0, 99) < 37) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.command        <= cmd;
        in_ch.char_code      <= c;
        in_ch.default_length <= dl;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
        if (parser_step(cmd, c, dl, r))
            pending_lengths.insert(pending_lengths.size(), typed ? want : r);
    endtask

    task automatic send_char(logic [7:0] c);
        send_item(mdep_pkg::CMD_CHAR, c, 8'($urandom));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_lengths.size() > 0) @(posedge clk);
    endtask

    // an open expression is closed first so the registers change with nothing in flight
    task automatic write_reg(logic idx, int unsigned val);
        if (stage != S_IDLE)
            send_item(mdep_pkg::CMD_EOL, 8'h00, 8'h00);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 10'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == mdep_pkg::REG_WHOLE) whole_steps = val;
        else                            quarter_steps = val;
    endtask

    task automatic send_digits(int n);
        repeat (n) send_char(mdep_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // %-prefixed step count: decimal, $hex or %binary, with optional sign
    task automatic send_percent_number();
        string hx;
        int n;
        hx = "0123456789abcdefABCDEFg";
        send_char(mdep_pkg::CH_PERCENT);
        if ($urandom_range(0, 3) == 0)
            send_char($urandom_range(0, 1) ? mdep_pkg::CH_SPACE : mdep_pkg::CH_TAB);
        case ($urandom_range(0, 3))
            0: send_char(mdep_pkg::CH_MINUS);
            1: send_char(mdep_pkg::CH_PLUS);
            default: ;
        endcase
        case ($urandom_range(0, 4))
            0, 1: send_digits($urandom_range(0, 9) == 0 ? 6 : $urandom_range(1, 5));
            2: begin
                send_char(mdep_pkg::CH_DOLLAR);
                repeat ($urandom_range(0, 2)) send_char(hx[$urandom_range(0, 22)]);
            end
            3: begin
                send_char(mdep_pkg::CH_PERCENT);
                n = $urandom_range(0, 10);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) send_char(mdep_pkg::CH_UNDER);
                    send_char($urandom_range(0, 1) ? mdep_pkg::CH_ONE : mdep_pkg::CH_ZERO);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_length_part();
        case ($urandom_range(0, 2))
            0: ;
            1: send_percent_number();
            2: send_digits($urandom_range(0, 12) == 0 ? 6 : $urandom_range(1, 3));
        endcase
        repeat ($urandom_range(0, 3)) send_char(mdep_pkg::CH_DOT);
    endtask

    task automatic send_expression();
        logic [7:0] dl;
        dl = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 16));
        send_item(mdep_pkg::CMD_BEGIN, 8'($urandom), dl);
        repeat ($urandom_range(0, 2))
            send_char($urandom_range(0, 1) ? mdep_pkg::CH_SPACE : mdep_pkg::CH_TAB);
        send_length_part();
        repeat ($urandom_range(0, 4)) begin
            send_char($urandom_range(0, 1) ? mdep_pkg::CH_CARET : mdep_pkg::CH_TILDE);
            send_length_part();
        end
        case ($urandom_range(0, 2))
            0: ;
            1: send_char(mdep_pkg::CH_NUL);
            2: send_char(8'($urandom));
        endcase
        send_item(mdep_pkg::CMD_EOL, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_item(2'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // result checker and watchdog
    always @(posedge clk) begin
        length_t want;
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("mml_duration_expression_parser test failed");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_lengths.size() == 0)
                    report_mismatch("result with no expected length");
                else begin
                    want = pending_lengths.pop_front();
                    if (out_ch.duration !== want.dur)
                        report_mismatch($sformatf("duration %0d, expected %0d",
                                        out_ch.duration, want.dur));
                    if (out_ch.leftover_chars !== want.left)
                        report_mismatch($sformatf("leftover_chars %0d, expected %0d",
                                        out_ch.leftover_chars, want.left));
                    if (out_ch.clipped !== want.clip)
                        report_mismatch($sformatf("clipped %0b, expected %0b",
                                        out_ch.clipped, want.clip));
                end
            end
        end
    end

    always @(posedge clk)
        out_ch.ready <= rst_n && (calm || $urandom_range(0, 99) >= 37);

    initial begin
        int unsigned settings[5][2];
        length_t want;
        in_ch.valid          = 1'b0;
        in_ch.command        = mdep_pkg::CMD_NONE;
        in_ch.char_code      = '0;
        in_ch.default_length = '0;
        out_ch.ready         = 1'b0;
        settings = '{'{192, 48}, '{1, 1}, '{1023, 1023}, '{1023, 1}, '{0, 0}};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            want = '{16'(dir_rows[i].dur), 2'(dir_rows[i].left), dir_rows[i].clip};
            send_item(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].dl,
                      dir_rows[i].typed, want);
        end

        for (int p = 0; p < 5; p++) begin
            if (p == 4) begin
                settings[p][0] = $urandom_range(1, 1023);
                settings[p][1] = $urandom_range(1, 1023);
            end
            write_reg(mdep_pkg::REG_WHOLE, settings[p][0]);
            write_reg(mdep_pkg::REG_QUARTER, settings[p][1]);
            while (items_sent < (p + 1) * ITEM_GOAL / 5 + dir_rows.size()) begin
                calm = (p == 2);
                if (p == 1 && $urandom_range(0, 5) == 0)
                    drain();
                if ($urandom_range(0, 7) == 0) send_noise();
                else                           send_expression();
            end
            calm = 0;
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("mml_duration_expression_parser test passed");
        else
            $display("mml_duration_expression_parser test failed");
        $finish;
    end

endmodule
